@@ sv/lazy_range_add_max_tree_defines.svh @@
// assertion macros shared by the lazy range-add / range-max tree modules
// expects aclk and aresetn in scope where used
`ifndef LAZY_RANGE_ADD_MAX_TREE_DEFINES_SVH
`define LAZY_RANGE_ADD_MAX_TREE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define LRAMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define LRAMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lramt_pkg.sv @@
// types, constants and helpers for the lazy range-add / range-max tree
// no dependencies
`timescale 1ns / 1ps

package lramt_pkg;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_RAISE = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // fill pattern for node maxima after a clear
    localparam logic [63:0] NEG_FILL = 64'hC0C0_C0C0_C0C0_C0C0;
    // answer floor for a query, -0x3F3F3F3F3F3F3F3F
    localparam logic [63:0] NEG_QRY  = 64'hC0C0_C0C0_C0C0_C0C1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLR_STEP,
        OP_PUSH_START,
        OP_PUSH_RD,
        OP_PUSH_CHK,
        OP_PUSH_C0,
        OP_PUSH_C1,
        OP_PUSH_CLR,
        OP_RAISE_RD,
        OP_RAISE_WR,
        OP_PULL_START,
        OP_PULL_R0,
        OP_PULL_R1,
        OP_PULL_RP,
        OP_PULL_WR,
        OP_LOOP_START,
        OP_L_RD,
        OP_L_ADD,
        OP_L_MAX,
        OP_R_RD,
        OP_R_ADD,
        OP_R_MAX,
        OP_SHIFT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_hi;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       oob;
        logic       empty;
        logic       pend_nz;
        logic       lvl_is1;
        logic       p_is1;
        logic       l_lt_r;
        logic       l_odd;
        logic       r_odd;
        logic       clr_done;
        logic       out_busy;
    } dp_stat_t;

    // signed maximum of two 64-bit words
    function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
        return ($signed(a) < $signed(b)) ? b : a;
    endfunction

endpackage

@@ sv/lramt_ram.sv @@
// generic simple dual-port RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lramt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/lramt_ctrl.sv @@
// sequencer for the tree walks: push, raise, add/query sweep, pull, clear
// depends on lramt_pkg and lazy_range_add_max_tree_defines.svh
`timescale 1ns / 1ps
`include "lazy_range_add_max_tree_defines.svh"

module lramt_ctrl
    import lramt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLR,
        ST_PUSH_START,
        ST_PUSH_RD,
        ST_PUSH_CHK,
        ST_PUSH_C0,
        ST_PUSH_C1,
        ST_PUSH_CLR,
        ST_RAISE_RD,
        ST_RAISE_WR,
        ST_PULL_START,
        ST_PULL_R0,
        ST_PULL_R1,
        ST_PULL_RP,
        ST_PULL_WR,
        ST_LOOP_START,
        ST_L_TST,
        ST_L_OP,
        ST_R_TST,
        ST_R_OP,
        ST_WAIT_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ph_reg, ph_next;
    state_t push_done_st;
    logic   push_done_ph;

    assign s_ready = (state_reg == ST_IDLE);

    // where to go once a push pass reaches the bottom
    always_comb begin
        push_done_ph = ph_reg;
        if (!ph_reg) begin
            if (stat.mode == MODE_RAISE) begin
                push_done_st = ST_RAISE_RD;
            end else begin
                push_done_st = ST_PUSH_START;
                push_done_ph = 1'b1;
            end
        end else begin
            push_done_st = ST_LOOP_START;
        end
    end

    // next state and datapath command
    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd.op     = OP_NONE;
        cmd.sel_hi = ph_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                ph_next = 1'b0;
                case (stat.mode)
                    MODE_CLEAR: state_next = ST_CLR;
                    MODE_RAISE: state_next = stat.oob ? ST_IDLE : ST_PUSH_START;
                    default: begin
                        if (stat.empty) begin
                            state_next = (stat.mode == MODE_QUERY) ? ST_WAIT_OUT : ST_IDLE;
                        end else begin
                            state_next = ST_PUSH_START;
                        end
                    end
                endcase
            end
            ST_CLR: begin
                cmd.op = OP_CLR_STEP;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH_START: begin
                cmd.op     = OP_PUSH_START;
                state_next = ST_PUSH_RD;
            end
            ST_PUSH_RD: begin
                cmd.op     = OP_PUSH_RD;
                state_next = ST_PUSH_CHK;
            end
            ST_PUSH_CHK: begin
                cmd.op = OP_PUSH_CHK;
                if (stat.pend_nz) begin
                    state_next = ST_PUSH_C0;
                end else if (stat.lvl_is1) begin
                    state_next = push_done_st;
                    ph_next    = push_done_ph;
                end else begin
                    state_next = ST_PUSH_RD;
                end
            end
            ST_PUSH_C0: begin
                cmd.op     = OP_PUSH_C0;
                state_next = ST_PUSH_C1;
            end
            ST_PUSH_C1: begin
                cmd.op     = OP_PUSH_C1;
                state_next = ST_PUSH_CLR;
            end
            ST_PUSH_CLR: begin
                cmd.op = OP_PUSH_CLR;
                if (stat.lvl_is1) begin
                    state_next = push_done_st;
                    ph_next    = push_done_ph;
                end else begin
                    state_next = ST_PUSH_RD;
                end
            end
            ST_RAISE_RD: begin
                cmd.op     = OP_RAISE_RD;
                state_next = ST_RAISE_WR;
            end
            ST_RAISE_WR: begin
                cmd.op     = OP_RAISE_WR;
                ph_next    = 1'b0;
                state_next = ST_PULL_START;
            end
            ST_PULL_START: begin
                cmd.op     = OP_PULL_START;
                state_next = ST_PULL_R0;
            end
            ST_PULL_R0: begin
                cmd.op     = OP_PULL_R0;
                state_next = ST_PULL_R1;
            end
            ST_PULL_R1: begin
                cmd.op     = OP_PULL_R1;
                state_next = ST_PULL_RP;
            end
            ST_PULL_RP: begin
                cmd.op     = OP_PULL_RP;
                state_next = ST_PULL_WR;
            end
            ST_PULL_WR: begin
                cmd.op = OP_PULL_WR;
                if (stat.p_is1) begin
                    if ((stat.mode == MODE_ADD) && !ph_reg) begin
                        ph_next    = 1'b1;
                        state_next = ST_PULL_START;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_PULL_R0;
                end
            end
            ST_LOOP_START: begin
                cmd.op     = OP_LOOP_START;
                state_next = ST_L_TST;
            end
            ST_L_TST: begin
                if (!stat.l_lt_r) begin
                    if (stat.mode == MODE_QUERY) begin
                        state_next = ST_WAIT_OUT;
                    end else begin
                        ph_next    = 1'b0;
                        state_next = ST_PULL_START;
                    end
                end else if (stat.l_odd) begin
                    cmd.op     = OP_L_RD;
                    state_next = ST_L_OP;
                end else begin
                    state_next = ST_R_TST;
                end
            end
            ST_L_OP: begin
                cmd.op     = (stat.mode == MODE_QUERY) ? OP_L_MAX : OP_L_ADD;
                state_next = ST_R_TST;
            end
            ST_R_TST: begin
                if (stat.r_odd) begin
                    cmd.op     = OP_R_RD;
                    state_next = ST_R_OP;
                end else begin
                    cmd.op     = OP_SHIFT;
                    state_next = ST_L_TST;
                end
            end
            ST_R_OP: begin
                cmd.op     = (stat.mode == MODE_QUERY) ? OP_R_MAX : OP_R_ADD;
                state_next = ST_L_TST;
            end
            ST_WAIT_OUT: begin
                if (!stat.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register; reset starts with a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            ph_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    `LRAMT_ASSERT_IMP(a_wait_is_query, state_reg == ST_WAIT_OUT, stat.mode == MODE_QUERY, "result pending for a non-query request")
    `LRAMT_ASSERT_NEXT(a_push_children, (state_reg == ST_PUSH_CHK) && stat.pend_nz, state_reg == ST_PUSH_C0, "pending tag not pushed to children")

endmodule

@@ sv/lramt_datapath.sv @@
// node memory, walk registers and result register of the tree
// depends on lramt_pkg, lramt_ram and lazy_range_add_max_tree_defines.svh
`timescale 1ns / 1ps
`include "lazy_range_add_max_tree_defines.svh"

module lramt_datapath
    import lramt_pkg::*;
#(
    parameter int LEAVES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  s_mode,
    input  logic [10:0] s_left,
    input  logic [10:0] s_right,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_max_value
);

    localparam int H   = $clog2(LEAVES);
    localparam int AW  = H + 1;
    localparam int LW  = AW + 1;
    localparam int LVW = $clog2(H + 1);

    logic [1:0]   mode_reg;
    logic [10:0]  lo_reg;
    logic [10:0]  hi_reg;
    logic [63:0]  val_reg;
    logic [AW-1:0] leaf_reg;
    logic [LVW-1:0] lvl_reg;
    logic [AW-1:0] p_reg;
    logic [127:0] word_reg;
    logic [63:0]  a_reg;
    logic [LW-1:0] l_reg;
    logic [LW-1:0] r_reg;
    logic [63:0]  best_reg;
    logic [AW-1:0] cnt_reg;
    logic         m_valid_reg;
    logic [63:0]  out_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [127:0]  wr_data;
    logic [AW-1:0] rd_addr;
    logic [127:0]  rd_data;

    logic [63:0]   rd_max;
    logic [63:0]   rd_pend;
    logic          lo_big;
    logic [H-1:0]  hic;
    logic [H-1:0]  lo_h;
    logic [AW-1:0] sel_leaf;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] child0;
    logic [AW-1:0] child1;
    logic [LW-1:0] r_dec;

    lramt_ram #(
        .WIDTH (128),
        .DEPTH (2 * LEAVES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // span decode and node addressing
    assign rd_max    = rd_data[127:64];
    assign rd_pend   = rd_data[63:0];
    assign lo_big    = 32'(lo_reg) >= 32'(LEAVES);
    assign hic       = (32'(hi_reg) >= 32'(LEAVES)) ? H'(LEAVES - 1) : H'(hi_reg);
    assign lo_h      = H'(lo_reg);
    assign sel_leaf  = {1'b1, cmd.sel_hi ? hic : lo_h};
    assign push_addr = leaf_reg >> lvl_reg;
    assign child0    = {p_reg[AW-2:0], 1'b0};
    assign child1    = {p_reg[AW-2:0], 1'b1};
    assign r_dec     = r_reg - LW'(1);

    // status towards the controller
    always_comb begin
        stat.mode     = mode_reg;
        stat.oob      = lo_big;
        stat.empty    = lo_big || (32'(hic) < 32'(lo_reg));
        stat.pend_nz  = (rd_pend != 64'd0);
        stat.lvl_is1  = (lvl_reg == LVW'(1));
        stat.p_is1    = (p_reg == AW'(1));
        stat.l_lt_r   = (l_reg < r_reg);
        stat.l_odd    = l_reg[0];
        stat.r_odd    = r_reg[0];
        stat.clr_done = (cnt_reg == {AW{1'b1}});
        stat.out_busy = m_valid_reg;
    end

    // memory port control
    always_comb begin
        rd_addr = p_reg;
        wr_en   = 1'b0;
        wr_addr = p_reg;
        wr_data = word_reg;
        case (cmd.op)
            OP_CLR_STEP: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = {NEG_FILL, 64'd0};
            end
            OP_PUSH_RD:  rd_addr = push_addr;
            OP_PUSH_CHK: rd_addr = child0;
            OP_PUSH_C0: begin
                wr_en   = 1'b1;
                wr_addr = child0;
                wr_data = {rd_max + word_reg[63:0], rd_pend + word_reg[63:0]};
                rd_addr = child1;
            end
            OP_PUSH_C1: begin
                wr_en   = 1'b1;
                wr_addr = child1;
                wr_data = {rd_max + word_reg[63:0], rd_pend + word_reg[63:0]};
            end
            OP_PUSH_CLR: begin
                wr_en   = 1'b1;
                wr_data = {word_reg[127:64], 64'd0};
            end
            OP_RAISE_RD: rd_addr = leaf_reg;
            OP_RAISE_WR: begin
                wr_en   = 1'b1;
                wr_addr = leaf_reg;
                wr_data = {smax(rd_max, val_reg), rd_pend};
            end
            OP_PULL_R0: rd_addr = child0;
            OP_PULL_R1: rd_addr = child1;
            OP_PULL_RP: rd_addr = p_reg;
            OP_PULL_WR: begin
                wr_en   = 1'b1;
                wr_data = {a_reg + rd_pend, rd_pend};
            end
            OP_L_RD: rd_addr = l_reg[AW-1:0];
            OP_L_ADD: begin
                wr_en   = 1'b1;
                wr_addr = l_reg[AW-1:0];
                wr_data = {rd_max + val_reg, rd_pend + val_reg};
            end
            OP_R_RD: rd_addr = r_dec[AW-1:0];
            OP_R_ADD: begin
                wr_en   = 1'b1;
                wr_addr = r_reg[AW-1:0];
                wr_data = {rd_max + val_reg, rd_pend + val_reg};
            end
            default: ;
        endcase
    end

    // walk registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                mode_reg <= s_mode;
                lo_reg   <= s_left;
                hi_reg   <= s_right;
                val_reg  <= s_value;
                best_reg <= NEG_QRY;
            end
            OP_PUSH_START: begin
                leaf_reg <= sel_leaf;
                lvl_reg  <= LVW'(H);
            end
            OP_PUSH_RD: p_reg <= push_addr;
            OP_PUSH_CHK: begin
                word_reg <= rd_data;
                if (rd_pend == 64'd0) begin
                    lvl_reg <= lvl_reg - LVW'(1);
                end
            end
            OP_PUSH_CLR:   lvl_reg <= lvl_reg - LVW'(1);
            OP_PULL_START: p_reg <= sel_leaf >> 1;
            OP_PULL_R1:    a_reg <= rd_max;
            OP_PULL_RP:    a_reg <= smax(a_reg, rd_max);
            OP_PULL_WR:    p_reg <= p_reg >> 1;
            OP_LOOP_START: begin
                l_reg <= LW'(LEAVES) + LW'(lo_h);
                r_reg <= LW'(LEAVES) + LW'(hic) + LW'(1);
            end
            OP_L_ADD: l_reg <= l_reg + LW'(1);
            OP_L_MAX: begin
                l_reg    <= l_reg + LW'(1);
                best_reg <= smax(best_reg, rd_max);
            end
            OP_R_RD: r_reg <= r_dec;
            OP_R_ADD, OP_SHIFT: begin
                l_reg <= l_reg >> 1;
                r_reg <= r_reg >> 1;
            end
            OP_R_MAX: begin
                l_reg    <= l_reg >> 1;
                r_reg    <= r_reg >> 1;
                best_reg <= smax(best_reg, rd_max);
            end
            OP_OUT: out_reg <= best_reg;
            default: ;
        endcase
    end

    // clear sweep counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_ACCEPT) begin
                cnt_reg <= '0;
            end else if (cmd.op == OP_CLR_STEP) begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_max_value = out_reg;

    `LRAMT_ASSERT_IMP(a_out_free, cmd.op == OP_OUT, !m_valid_reg, "result register overwritten")
    `LRAMT_ASSERT_NEXT(a_out_drain, m_valid_reg && m_ready, !m_valid_reg, "result request not released")

endmodule

@@ sv/lazy_range_add_max_tree.sv @@
// lazy range-add / range-max tree, one request at a time, node memory 2*LEAVES x 128 bits.
// a new request is taken once the previous one finishes. reset (synchronous, aresetn
// low) runs the same clearing pass as a clear request, with s_ready low, before the
// first request is taken.
`timescale 1ns / 1ps

module lazy_range_add_max_tree
    import lramt_pkg::*;
#(
    parameter int LEAVES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [10:0] s_left,
    input  logic [10:0] s_right,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_max_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    lramt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // node memory and walk datapath
    lramt_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_mode      (s_mode),
        .s_left      (s_left),
        .s_right     (s_right),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_max_value (m_max_value)
    );

endmodule

@@ dv/lazy_range_add_max_tree_tb.sv @@
// testbench for the lazy range-add / range-max tree: random and directed requests
// checked against a behavioural tree model held in a scoreboard class
// depends on lramt_pkg and lazy_range_add_max_tree
`timescale 1ns / 1ps

module lazy_range_add_max_tree_tb;
    import lramt_pkg::*;

    localparam int LEAVES = 2048;
    localparam int HEIGHT = 11;
    localparam longint unsigned CYCLE_LIMIT = 3_000_000;

    // tree model and queue of pending query answers
    class max_tree_board;
        logic [63:0] node_max [2*LEAVES];
        logic [63:0] pend_add [2*LEAVES];
        logic [63:0] answers [$];
        int errors;

        function void clear_tree();
            for (int i = 0; i < 2*LEAVES; i++) begin
                node_max[i] = NEG_FILL;
                pend_add[i] = '0;
            end
        endfunction

        function void tag(int p, logic [63:0] v);
            node_max[p] = node_max[p] + v;
            pend_add[p] = pend_add[p] + v;
        endfunction

        function void push_down(int leaf);
            int p;
            for (int i = HEIGHT; i >= 1; i--) begin
                p = leaf >> i;
                if (p != 0 && p < LEAVES && pend_add[p] != 0) begin
                    tag(2*p, pend_add[p]);
                    tag(2*p+1, pend_add[p]);
                    pend_add[p] = '0;
                end
            end
        endfunction

        function void pull_up(int leaf);
            logic [63:0] a, b;
            for (int p = leaf >> 1; p >= 1; p = p >> 1) begin
                a = node_max[2*p];
                b = node_max[2*p+1];
                node_max[p] = (($signed(a) < $signed(b)) ? b : a) + pend_add[p];
            end
        endfunction

        // note an accepted request and queue any answer it gives
        function void note_request(logic [1:0] mode, int lo, int hi, logic [63:0] v);
            int l, r;
            logic [63:0] best;
            if (mode == MODE_CLEAR) begin
                clear_tree();
                return;
            end
            if (mode == MODE_RAISE) begin
                l = LEAVES + lo;
                push_down(l);
                if ($signed(node_max[l]) < $signed(v)) node_max[l] = v;
                pull_up(l);
                return;
            end
            if (hi >= LEAVES) hi = LEAVES - 1;
            if (lo >= LEAVES || hi < lo) begin
                if (mode == MODE_QUERY) answers.push_back(NEG_QRY);
                return;
            end
            l = LEAVES + lo;
            r = LEAVES + hi + 1;
            push_down(l);
            push_down(r - 1);
            best = NEG_QRY;
            for (; l < r; l = l >> 1, r = r >> 1) begin
                if (l & 1) begin
                    if (mode == MODE_ADD) tag(l, v);
                    else if ($signed(best) < $signed(node_max[l])) best = node_max[l];
                    l++;
                end
                if (r & 1) begin
                    r--;
                    if (mode == MODE_ADD) tag(r, v);
                    else if ($signed(best) < $signed(node_max[r])) best = node_max[r];
                end
            end
            if (mode == MODE_ADD) begin
                pull_up(LEAVES + lo);
                pull_up(LEAVES + hi);
            end else begin
                answers.push_back(best);
            end
        endfunction

        // compare one answer with the oldest one due
        function void check_answer(logic [63:0] got);
            logic [63:0] want;
            if (answers.size() == 0) begin
                $display("%0t: unexpected answer %h", $time, got);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (got !== want) begin
                $display("%0t: max_value expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [10:0] s_left;
    logic [10:0] s_right;
    logic [63:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_max_value;

    max_tree_board board;
    int  sent_count;
    bit  hold_rx;
    bit  calm;
    longint unsigned cycles;

    lazy_range_add_max_tree #(.LEAVES(LEAVES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .s_left(s_left), .s_right(s_right), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_max_value(m_max_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) board.check_answer(m_max_value);
            m_ready <= !hold_rx && (calm || $urandom_range(99) >= 29);
        end
    end

    // offer one request and wait for it to be taken; valid stays high until the next call
    task automatic send_request(logic [1:0] mode, logic [10:0] lo, logic [10:0] hi,
                                logic [63:0] v);
        while (!calm && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_left  <= lo;
        s_right <= hi;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        board.note_request(mode, lo, hi, v);
        sent_count++;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(3);
            2: return 64'h8000_0000_0000_0000 + $urandom_range(3);
            default: return {{32{1'b0}}, $urandom} - 64'd2147483648;
        endcase
    endfunction

    // mostly narrow positions so answers depend on earlier updates
    task automatic random_request();
        logic [1:0]  mode;
        logic [10:0] lo, hi;
        int k;
        k = $urandom_range(99);
        mode = (k < 2) ? MODE_CLEAR : (k < 35) ? MODE_RAISE : (k < 65) ? MODE_ADD
                                                              : MODE_QUERY;
        if ($urandom_range(3) == 0) begin
            lo = $urandom;
            hi = $urandom;
        end else begin
            lo = $urandom_range(63);
            hi = lo + $urandom_range(40) - 4;
        end
        send_request(mode, lo, hi, rand_value());
    endtask

    task automatic drain();
        while (board.answers.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        board = new();
        board.clear_tree();
        cycles = 0;
        sent_count = 0;
        hold_rx = 1'b0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_QUERY;
        s_left = '0;
        s_right = '0;
        s_value = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, empty spans, positions at both ends, wrap
        send_request(MODE_QUERY, 11'd0, 11'd2047, '0);
        send_request(MODE_QUERY, 11'd5, 11'd4, '0);
        send_request(MODE_ADD, 11'd9, 11'd3, 64'd77);
        send_request(MODE_RAISE, 11'd0, 11'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(MODE_RAISE, 11'd2047, 11'd0, 64'h8000_0000_0000_0000);
        send_request(MODE_RAISE, 11'd1024, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(MODE_QUERY, 11'd0, 11'd0, '0);
        send_request(MODE_QUERY, 11'd2047, 11'd2047, '0);
        send_request(MODE_ADD, 11'd0, 11'd2047, 64'd1);
        send_request(MODE_QUERY, 11'd0, 11'd2047, '0);
        send_request(MODE_ADD, 11'd1, 11'd2046, 64'h5555_5555_5555_5555);
        send_request(MODE_QUERY, 11'd1000, 11'd1100, '0);
        send_request(MODE_ADD, 11'd1030, 11'd1030, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(MODE_QUERY, 11'd1024, 11'd1030, '0);
        send_request(MODE_CLEAR, 11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(MODE_QUERY, 11'd0, 11'd2047, '0);
        send_request(MODE_RAISE, 11'd3, 11'd0, 64'd12);
        send_request(MODE_QUERY, 11'd2, 11'd1500, '0);

        // receiver holds off while requests keep coming
        fork
            begin
                hold_rx = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_rx = 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++) begin
                    send_request(MODE_QUERY, 11'(i), 11'(i + 8), '0);
                end
                s_valid <= 1'b0;
            end
        join

        // sender pauses until all answers are back
        drain();

        for (int i = 0; i < 1350; i++) begin
            calm = (i >= 500 && i < 700);
            random_request();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        drain();
        if (board.errors == 0 && board.answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
